>>> hdl/c2s_pkg.sv
package c2s_pkg;

	// angle accumulator width, Q.24 radians
	localparam int AW = 28;
	localparam int HALF_PI_Q24 = 26353589;
	localparam logic [30:0] GAIN_Q30 = 31'd1768195363;
	localparam int PI_Q13 = 25736;

	// round(atan(2^-i) * 2^24)
	function automatic logic signed [AW-1:0] atan_q24(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0: r = 28'sd13176795;
			1: r = 28'sd7778716;
			2: r = 28'sd4110060;
			3: r = 28'sd2086331;
			4: r = 28'sd1047214;
			5: r = 28'sd524117;
			6: r = 28'sd262123;
			7: r = 28'sd131069;
			8: r = 28'sd65536;
			9: r = 28'sd32768;
			10: r = 28'sd16384;
			11: r = 28'sd8192;
			12: r = 28'sd4096;
			13: r = 28'sd2048;
			14: r = 28'sd1024;
			15: r = 28'sd512;
			16: r = 28'sd256;
			17: r = 28'sd128;
			18: r = 28'sd64;
			19: r = 28'sd32;
			20: r = 28'sd16;
			21: r = 28'sd8;
			22: r = 28'sd4;
			23: r = 28'sd2;
			24: r = 28'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/c2s_delay.sv
module c2s_delay #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] r_q [N];

	// advance the delay line
	always_ff @(posedge clk) begin
		if (en) begin
			r_q[0] <= d;
			for (int i = 1; i < N; i++) r_q[i] <= r_q[i-1];
		end
	end

	assign q = r_q[N-1];

endmodule

>>> hdl/c2s_prerot.sv
module c2s_prerot #(
	parameter int VW = 44
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [VW-1:0]        x_in,
	input  logic signed [VW-1:0]        y_in,
	output logic signed [VW-1:0]        x_q,
	output logic signed [VW-1:0]        y_q,
	output logic signed [c2s_pkg::AW-1:0] a_q
);

	localparam logic signed [c2s_pkg::AW-1:0] HP = c2s_pkg::AW'(c2s_pkg::HALF_PI_Q24);

	// fold the left half plane onto the right by a quarter turn
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_in[VW-1] && !y_in[VW-1]) begin
				x_q <= y_in;
				y_q <= -x_in;
				a_q <= HP;
			end else if (x_in[VW-1]) begin
				x_q <= -y_in;
				y_q <= x_in;
				a_q <= -HP;
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				a_q <= '0;
			end
		end
	end

endmodule

>>> hdl/c2s_cordic_cell.sv
module c2s_cordic_cell #(
	parameter int VW = 44,
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [VW-1:0]          x_in,
	input  logic signed [VW-1:0]          y_in,
	input  logic signed [c2s_pkg::AW-1:0] a_in,
	output logic signed [VW-1:0]          x_q,
	output logic signed [VW-1:0]          y_q,
	output logic signed [c2s_pkg::AW-1:0] a_q
);

	localparam logic signed [c2s_pkg::AW-1:0] ATAN = c2s_pkg::atan_q24(IDX);

	logic signed [VW-1:0] dx, dy;

	assign dx = y_in >>> IDX;
	assign dy = x_in >>> IDX;

	// rotate toward the x axis, steering by the sign of y
	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[VW-1]) begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				a_q <= a_in + ATAN;
			end else begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				a_q <= a_in - ATAN;
			end
		end
	end

endmodule

>>> hdl/c2s_sqrt_cell.sv
module c2s_sqrt_cell #(
	parameter int NW = 32,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] n_in,
	input  logic [NW-1:0] r_in,
	output logic [NW-1:0] n_q,
	output logic [NW-1:0] r_q
);

	localparam logic [NW-1:0] BIT = {{(NW-1){1'b0}}, 1'b1} << (NW - 2 - 2 * IDX);

	logic [NW-1:0] trial;

	assign trial = r_in + BIT;

	// settle one root bit
	always_ff @(posedge clk) begin
		if (en) begin
			if (n_in >= trial) begin
				n_q <= n_in - trial;
				r_q <= (r_in >> 1) + BIT;
			end else begin
				n_q <= n_in;
				r_q <= r_in >> 1;
			end
		end
	end

endmodule

>>> hdl/cartesian_to_spherical_unit.sv
// Converts a point (x, y, z) to radius, azimuth atan2(y,x) and polar angle
// acos(z/r), angles in radians as Q3.13, radius rounded to nearest. One point
// is taken every cycle while the input is not stalled; each result passes
// through the two CORDIC cell rows in series, with the square root cell row
// beside them. A two-entry output buffer absorbs a stalled master side; input
// stalls only when both entries are full. Azimuth is 0 when x=y=0, polar
// angle is 0 when x=y=z=0 or when three_d_mode is 0 (reset value 1).
module cartesian_to_spherical_unit #(
	parameter int COORD_WIDTH = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// coord_x, coord_y, coord_z
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// radius[15:0], azimuth[31:16], polar_angle[46:32]
	output logic [47:0]                            m_tdata,
	input  logic                                   cfg_wr_en,
	input  logic                                   cfg_wr_data
);

	localparam int CW = COORD_WIDTH;
	localparam int CS = CORDIC_STAGES;
	localparam int AW = c2s_pkg::AW;
	localparam int VW = CW + 28;
	localparam int NW = 2 * CW;
	localparam int PW = CW + 32;
	localparam int EC = 2 * CS + 2;
	localparam int ES = CW + 1;
	localparam int E = (EC > ES) ? EC : ES;

	logic adv;
	logic [E:0] v_q;
	logic three_d_mode_q;

	// hold the mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			three_d_mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			three_d_mode_q <= cfg_wr_data;
		end
	end

	// advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[E-1:0], s_tvalid};
		end
	end

	// stage 1: squares, z times gain, zero flags
	logic signed [CW-1:0] cx, cy, cz;
	logic [NW-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [PW-1:0] zprod_s1;
	logic signed [CW-1:0] x_s1, y_s1;
	logic [1:0] flags_s1;

	assign cx = s_tdata[CW-1:0];
	assign cy = s_tdata[2*CW-1:CW];
	assign cz = s_tdata[3*CW-1:2*CW];

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s1 <= NW'(cx * cx);
			sqy_s1 <= NW'(cy * cy);
			sqz_s1 <= NW'(cz * cz);
			zprod_s1 <= PW'(cz * $signed({1'b0, c2s_pkg::GAIN_Q30}));
			x_s1 <= cx;
			y_s1 <= cy;
			flags_s1 <= {(cx == '0) && (cy == '0) && (cz == '0),
				(cx == '0) && (cy == '0)};
		end
	end

	// stage 2: sum of squares, scaled z
	logic [NW-1:0] sum_s2;
	logic signed [VW-1:0] zk_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= sqx_s1 + sqy_s1 + sqz_s1;
			zk_s2 <= VW'(zprod_s1 >>> 6);
		end
	end

	// azimuth cell row
	logic signed [VW-1:0] ax [0:CS];
	logic signed [VW-1:0] ay [0:CS];
	logic signed [AW-1:0] aa [0:CS];

	c2s_prerot #(.VW(VW)) u_az_pre (
		.clk(clk), .en(adv),
		.x_in(VW'(x_s1) <<< 24), .y_in(VW'(y_s1) <<< 24),
		.x_q(ax[0]), .y_q(ay[0]), .a_q(aa[0])
	);

	for (genvar j = 0; j < CS; j++) begin : g_az
		c2s_cordic_cell #(.VW(VW), .IDX(j)) u_cell (
			.clk(clk), .en(adv),
			.x_in(ax[j]), .y_in(ay[j]), .a_in(aa[j]),
			.x_q(ax[j+1]), .y_q(ay[j+1]), .a_q(aa[j+1])
		);
	end

	// polar cell row, fed by the gained planar length
	logic [VW-1:0] zk_d;
	logic signed [VW-1:0] px [0:CS];
	logic signed [VW-1:0] py [0:CS];
	logic signed [AW-1:0] pa [0:CS];

	c2s_delay #(.W(VW), .N(CS)) u_zk_dly (
		.clk(clk), .en(adv), .d(zk_s2), .q(zk_d)
	);

	c2s_prerot #(.VW(VW)) u_pol_pre (
		.clk(clk), .en(adv),
		.x_in($signed(zk_d)), .y_in(ax[CS]),
		.x_q(px[0]), .y_q(py[0]), .a_q(pa[0])
	);

	for (genvar j = 0; j < CS; j++) begin : g_pol
		c2s_cordic_cell #(.VW(VW), .IDX(j)) u_cell (
			.clk(clk), .en(adv),
			.x_in(px[j]), .y_in(py[j]), .a_in(pa[j]),
			.x_q(px[j+1]), .y_q(py[j+1]), .a_q(pa[j+1])
		);
	end

	// square root cell row
	logic [NW-1:0] sn [0:CW];
	logic [NW-1:0] sr [0:CW];

	assign sn[0] = sum_s2;
	assign sr[0] = '0;

	for (genvar j = 0; j < CW; j++) begin : g_sqrt
		c2s_sqrt_cell #(.NW(NW), .IDX(j)) u_cell (
			.clk(clk), .en(adv),
			.n_in(sn[j]), .r_in(sr[j]), .n_q(sn[j+1]), .r_q(sr[j+1])
		);
	end

	// align all rows to the last stage
	logic [1:0] flags_e;
	logic [AW-1:0] az_e, pol_e;
	logic [2*NW-1:0] sq_e;

	c2s_delay #(.W(2), .N(E)) u_flag_dly (
		.clk(clk), .en(adv), .d(flags_s1), .q(flags_e)
	);

	c2s_delay #(.W(AW), .N(E - 1 - CS)) u_az_dly (
		.clk(clk), .en(adv), .d(aa[CS]), .q(az_e)
	);

	if (E > EC) begin : g_pol_pad
		c2s_delay #(.W(AW), .N(E - EC)) u_dly (
			.clk(clk), .en(adv), .d(pa[CS]), .q(pol_e)
		);
	end else begin : g_pol_nopad
		assign pol_e = pa[CS];
	end

	if (E > ES) begin : g_sq_pad
		c2s_delay #(.W(2 * NW), .N(E - ES)) u_dly (
			.clk(clk), .en(adv), .d({sn[CW], sr[CW]}), .q(sq_e)
		);
	end else begin : g_sq_nopad
		assign sq_e = {sn[CW], sr[CW]};
	end

	// round and clamp the results
	localparam logic signed [AW-1:0] PI_LIM = AW'(c2s_pkg::PI_Q13);
	logic signed [AW-1:0] az_rnd, pol_rnd;
	logic [NW-1:0] rad_rnd;
	logic [15:0] az_out;
	logic [14:0] pol_out;
	logic [47:0] res_data;

	always_comb begin
		az_rnd = ($signed(az_e) + AW'(1024)) >>> 11;
		pol_rnd = ($signed(pol_e) + AW'(1024)) >>> 11;
		rad_rnd = sq_e[NW-1:0] + NW'(sq_e[2*NW-1:NW] > sq_e[NW-1:0]);
		if (flags_e[0]) begin
			az_out = '0;
		end else if (az_rnd > PI_LIM) begin
			az_out = 16'(PI_LIM);
		end else if (az_rnd < -PI_LIM) begin
			az_out = 16'(-PI_LIM);
		end else begin
			az_out = az_rnd[15:0];
		end
		if (flags_e[1] || !three_d_mode_q || pol_rnd < 0) begin
			pol_out = '0;
		end else if (pol_rnd > PI_LIM) begin
			pol_out = 15'(PI_LIM);
		end else begin
			pol_out = pol_rnd[14:0];
		end
		res_data = {1'b0, pol_out, az_out, rad_rnd[15:0]};
	end

	// output register and skid entry
	logic out_v_q, sk_v_q, arrive;
	logic [47:0] out_q, sk_q;

	assign adv = !sk_v_q;
	assign arrive = adv && v_q[E];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (out_v_q && m_tready) begin
			if (sk_v_q) begin
				sk_v_q <= 1'b0;
			end else begin
				out_v_q <= arrive;
			end
		end else if (arrive) begin
			if (out_v_q) begin
				sk_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && m_tready) begin
			out_q <= sk_v_q ? sk_q : res_data;
		end else if (arrive && !out_v_q) begin
			out_q <= res_data;
		end
		if (arrive && out_v_q && !m_tready) begin
			sk_q <= res_data;
		end
	end

	assign s_tready = adv;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	// skid entry is only ever used behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid entry full while output register empty");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid filled without a stall");

	// 2D mode yields a zero polar angle
	a_polar_2d: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !three_d_mode_q && !sk_v_q && !$past(cfg_wr_en)) |->
		(m_tdata[46:32] == 15'd0))
		else $error("polar angle nonzero in 2D mode");

endmodule

>>> verif/c2s_checker.sv
module c2s_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	output int          errors,
	output int          pending,
	output int          points_seen,
	output int          polar_nonzero
);

	typedef struct packed {
		logic [15:0]        radius;
		logic signed [15:0] azimuth;
		logic [14:0]        polar;
	} sph_t;

	localparam longint ARCTAN_Q24 [16] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
	};

	sph_t spherical_q[$];
	logic polar_enabled;

	// vectoring CORDIC: angle in Q.24, scaled magnitude out through mag
	function automatic longint vector_angle(input longint xi, input longint yi,
			output longint mag);
		longint x, y, ang, t, dx, dy;
		x = xi;
		y = yi;
		ang = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			return 0;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				ang = c2s_pkg::HALF_PI_Q24;
			end else begin
				x = -y;
				y = t;
				ang = -c2s_pkg::HALF_PI_Q24;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				ang += ARCTAN_Q24[i];
			end else begin
				x -= dx;
				y += dy;
				ang -= ARCTAN_Q24[i];
			end
		end
		mag = x;
		return ang;
	endfunction

	function automatic longint angle_q13(input longint a, input longint lo, input longint hi);
		longint q;
		q = (a + 1024) >>> 11;
		if (q < lo) q = lo;
		if (q > hi) q = hi;
		return q;
	endfunction

	// integer square root rounded to nearest
	function automatic longint unsigned rounded_sqrt(input longint unsigned n);
		longint unsigned res, bits, rem;
		res = 0;
		rem = n;
		bits = 64'd1 << 62;
		while (bits > rem) bits >>= 2;
		while (bits != 0) begin
			if (rem >= res + bits) begin
				rem -= res + bits;
				res = (res >> 1) + bits;
			end else begin
				res >>= 1;
			end
			bits >>= 2;
		end
		if (rem > res) res++;
		return res;
	endfunction

	function automatic sph_t spherical_of(input logic [47:0] d, input logic mode3d);
		longint x, y, z, rho, unused, az_q24, pol_q24, zk;
		sph_t r;
		x = longint'($signed(d[15:0]));
		y = longint'($signed(d[31:16]));
		z = longint'($signed(d[47:32]));
		r.radius = 16'(rounded_sqrt(longint'(x*x + y*y + z*z)));
		az_q24 = vector_angle(x <<< 24, y <<< 24, rho);
		r.azimuth = 16'(angle_q13(az_q24, -c2s_pkg::PI_Q13, c2s_pkg::PI_Q13));
		r.polar = '0;
		if (mode3d) begin
			zk = (z * longint'(c2s_pkg::GAIN_Q30)) >>> 6;
			pol_q24 = vector_angle(zk, rho, unused);
			r.polar = 15'(angle_q13(pol_q24, 0, c2s_pkg::PI_Q13));
		end
		return r;
	endfunction

	// track the mode, queue predictions, compare each output transfer
	always @(posedge clk or negedge arst_n) begin
		sph_t want, got;
		if (!arst_n) begin
			polar_enabled <= 1'b1;
			errors = 0;
			points_seen = 0;
			polar_nonzero = 0;
			spherical_q.delete();
			pending = 0;
		end else begin
			if (cfg_wr_en) polar_enabled <= cfg_wr_data;
			if (s_tvalid && s_tready) begin
				spherical_q.push_back(spherical_of(s_tdata, polar_enabled));
				points_seen++;
			end
			if (m_tvalid && m_tready) begin
				got.radius = m_tdata[15:0];
				got.azimuth = m_tdata[31:16];
				got.polar = m_tdata[46:32];
				if (spherical_q.size() == 0) begin
					$error("unexpected result transfer %h", m_tdata);
					errors++;
				end else begin
					want = spherical_q.pop_front();
					if (got.polar != 0) polar_nonzero++;
					if (got.radius !== want.radius) begin
						$error("radius: expected %0d got %0d", want.radius, got.radius);
						errors++;
					end
					if (got.azimuth !== want.azimuth) begin
						$error("azimuth: expected %0d got %0d", want.azimuth, got.azimuth);
						errors++;
					end
					if (got.polar !== want.polar) begin
						$error("polar_angle: expected %0d got %0d", want.polar, got.polar);
						errors++;
					end
				end
			end
			pending = spherical_q.size();
		end
	end

endmodule

>>> verif/tb_cartesian_to_spherical_unit.sv
module tb_cartesian_to_spherical_unit;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        steady = 1'b0;
	int          errors, pending, points_seen, polar_nonzero;

	always #5 clk = ~clk;

	cartesian_to_spherical_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	c2s_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.errors(errors), .pending(pending),
		.points_seen(points_seen), .polar_nonzero(polar_nonzero)
	);

	// stall the result side at random unless in a steady stretch
	always @(negedge clk)
		m_tready <= !arst_n ? 1'b0 : (steady || $urandom_range(99) >= 28);

	// hand one point over, with random gaps ahead of it
	task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		while (!steady && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_mode(input logic m);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'($signed($urandom_range(16)) - 8);
			2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			3: return 16'($signed($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_points(input int n);
		logic [15:0] x, y, z;
		for (int i = 0; i < n; i++) begin
			x = pick_coord();
			y = pick_coord();
			z = pick_coord();
			// land on an axis now and then
			if ($urandom_range(9) == 0) begin
				x = '0;
				y = '0;
			end
			send_point(x, y, z);
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners, origin, axes and quadrant boundaries
		send_point(16'h0000, 16'h0000, 16'h0000);
		send_point(16'h0000, 16'h0000, 16'h0005);
		send_point(16'h0000, 16'h0000, 16'hFFFB);
		send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_point(16'h8000, 16'h8000, 16'h8000);
		send_point(16'h8000, 16'h0000, 16'h0000);
		send_point(16'h8000, 16'hFFFF, 16'h0000);
		send_point(16'h8000, 16'h0001, 16'h0000);
		send_point(16'h0000, 16'h7FFF, 16'h0000);
		send_point(16'h0000, 16'h8000, 16'h0000);
		send_point(16'h7FFF, 16'h0000, 16'h8000);
		send_point(16'hFFFF, 16'h0000, 16'h0000);
		send_point(16'h0003, 16'h0004, 16'h0000);
		send_point(16'h0001, 16'h0001, 16'h0001);
		send_point(16'hFFFF, 16'hFFFF, 16'h7FFF);
		send_point(16'h8000, 16'h7FFF, 16'h0001);

		// flat data
		set_mode(1'b0);
		send_point(16'h0000, 16'h0000, 16'h0007);
		send_point(16'h8000, 16'h8000, 16'h8000);
		random_points(450);

		// back to full 3D with stalls on both sides
		set_mode(1'b1);
		random_points(450);

		// pause until the pipe is empty, then carry on without gaps
		drain();
		steady = 1'b1;
		random_points(450);
		steady = 1'b0;

		set_mode(1'b0);
		random_points(200);
		set_mode(1'b1);
		random_points(250);

		drain();
		$display("%0d points converted, %0d with a nonzero polar angle, across 2D and 3D modes",
			points_seen, polar_nonzero);
		if (errors == 0)
			$display("cartesian_to_spherical_unit verification clean");
		else
			$display("cartesian_to_spherical_unit verification failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout");
		$display("cartesian_to_spherical_unit verification failed");
		$finish;
	end

endmodule
